>>> rtl/core/x86_16_instruction_predecoder_top_macros.svh
// Assertion macros for the predecoder RTL, used in x86pd_collect.
// Depends on clk_i and rst_ni being visible in the module that uses them.
`ifndef X86_16_INSTRUCTION_PREDECODER_TOP_MACROS_SVH
`define X86_16_INSTRUCTION_PREDECODER_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Property that must hold at every edge outside reset
`define X86PD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Same-cycle implication
`define X86PD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`else
`define X86PD_ASSERT(lbl, prop, msg)
`define X86PD_ASSERT_IMP(lbl, ante, cons, msg)
`endif
`endif

>>> rtl/core/x86pd_pkg.sv
// Package for the 8086 instruction predecoder: kinds, opcode patterns,
// length helpers and the decoded result record. No dependencies.
package x86pd_pkg;

  typedef enum logic [2:0] {
    KIND_MOV_RM  = 3'd0,
    KIND_MOV_IMM = 3'd1,
    KIND_ADD_RM  = 3'd2,
    KIND_IMM_GRP = 3'd3,
    KIND_ADD_ACC = 3'd4,
    KIND_UNKNOWN = 3'd5
  } op_kind_e;

  // Opcode prefix patterns
  localparam logic [5:0] PAT_MOV_RM  = 6'b100010;
  localparam logic [3:0] PAT_MOV_IMM = 4'b1011;
  localparam logic [5:0] PAT_ADD_RM  = 6'b000000;
  localparam logic [5:0] PAT_IMM_GRP = 6'b100000;
  localparam logic [6:0] PAT_ADD_ACC = 7'b0000010;
  // ModRM codes
  localparam logic [2:0] RM_DIRECT   = 3'b110;
  localparam logic [1:0] MOD_REG     = 2'b11;
  localparam logic [1:0] MOD_DISP8   = 2'b01;
  localparam logic [1:0] MOD_DISP16  = 2'b10;
  localparam logic [1:0] MOD_NODISP  = 2'b00;

  typedef struct packed {
    op_kind_e           op_kind;
    logic               dir_bit;
    logic               wide_bit;
    logic               sign_ext_bit;
    logic [1:0]         mode_field;
    logic [2:0]         reg_num;
    logic [2:0]         rm_field;
    logic signed [15:0] displacement;
    logic [15:0]        immediate;
    logic [2:0]         instr_length;
  } result_t;

  function automatic op_kind_e classify(input logic [7:0] op);
    if (op[7:2] == PAT_MOV_RM)       return KIND_MOV_RM;
    else if (op[7:4] == PAT_MOV_IMM) return KIND_MOV_IMM;
    else if (op[7:2] == PAT_ADD_RM)  return KIND_ADD_RM;
    else if (op[7:2] == PAT_IMM_GRP) return KIND_IMM_GRP;
    else if (op[7:1] == PAT_ADD_ACC) return KIND_ADD_ACC;
    else                             return KIND_UNKNOWN;
  endfunction

  function automatic logic has_modrm(input op_kind_e kind);
    return (kind == KIND_MOV_RM) || (kind == KIND_ADD_RM) || (kind == KIND_IMM_GRP);
  endfunction

  function automatic logic [1:0] disp_count(input logic [7:0] modrm);
    logic [1:0] cnt;
    cnt = 2'd0;
    unique case (modrm[7:6])
      MOD_DISP8:  cnt = 2'd1;
      MOD_DISP16: cnt = 2'd2;
      MOD_NODISP: cnt = (modrm[2:0] == RM_DIRECT) ? 2'd2 : 2'd0;
      default:    cnt = 2'd0;
    endcase
    return cnt;
  endfunction

  function automatic logic wide_of(input op_kind_e kind, input logic [7:0] op);
    return (kind == KIND_MOV_IMM) ? op[3] : op[0];
  endfunction

  function automatic logic [1:0] imm_count(input op_kind_e kind, input logic [7:0] op);
    logic [1:0] cnt;
    cnt = 2'd0;
    if ((kind == KIND_MOV_RM) || (kind == KIND_ADD_RM)) cnt = 2'd0;
    else if (kind == KIND_IMM_GRP) cnt = (op[0] && !op[1]) ? 2'd2 : 2'd1;
    else cnt = wide_of(kind, op) ? 2'd2 : 2'd1;
    return cnt;
  endfunction

endpackage

>>> rtl/core/x86pd_byte_if.sv
// Code byte stream channel: valid/ready plus one byte.
// Depends on nothing.
interface x86pd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;

  modport source (output valid, output code_byte, input ready);
  modport sink   (input valid, input code_byte, output ready);
endinterface

>>> rtl/core/x86pd_res_if.sv
// Decoded instruction channel: valid/ready plus the decoded fields.
// Depends on nothing.
interface x86pd_res_if;
  logic               valid;
  logic               ready;
  logic [2:0]         op_kind;
  logic               dir_bit;
  logic               wide_bit;
  logic               sign_ext_bit;
  logic [1:0]         mode_field;
  logic [2:0]         reg_num;
  logic [2:0]         rm_field;
  logic signed [15:0] displacement;
  logic [15:0]        immediate;
  logic [2:0]         instr_length;

  modport source (output valid, output op_kind, output dir_bit, output wide_bit,
                  output sign_ext_bit, output mode_field, output reg_num,
                  output rm_field, output displacement, output immediate,
                  output instr_length, input ready);
  modport sink   (input valid, input op_kind, input dir_bit, input wide_bit,
                  input sign_ext_bit, input mode_field, input reg_num,
                  input rm_field, input displacement, input immediate,
                  input instr_length, output ready);
endinterface

>>> rtl/core/x86_16_instruction_predecoder_top.sv
// 8086 subset predecoder: one code byte per transfer, one decoded result per instruction.
// A result is valid the cycle after the transfer of its last byte.
// One byte per cycle while input ready is high; an instruction is 1..6 bytes long.
// Input ready drops only while a finished result waits in the result register.
// Reset (async, active low) clears the byte phase, all holds and the result valid.
// Uses x86pd_pkg, x86pd_byte_if, x86pd_res_if, x86pd_collect and x86pd_outreg.
module x86_16_instruction_predecoder_top
  import x86pd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  x86pd_byte_if.sink  code_i,
  x86pd_res_if.source result_o
);

  logic    take;
  logic    done;
  logic    free;
  result_t res;

  assign code_i.ready = free;
  assign take         = code_i.valid && free;

  x86pd_collect u_collect (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (take),
    .byte_i (code_i.code_byte),
    .done_o (done),
    .res_o  (res)
  );

  x86pd_outreg u_outreg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (done),
    .res_i    (res),
    .free_o   (free),
    .result_o (result_o)
  );

endmodule

>>> rtl/core/x86pd_collect.sv
// Byte phase machine: holds opcode, ModRM, displacement and immediate bytes
// and assembles the decoded record on the last byte. Uses x86pd_pkg.
module x86pd_collect
  import x86pd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       take_i,
  input  logic [7:0] byte_i,
  output logic       done_o,
  output result_t    res_o
);

`include "x86_16_instruction_predecoder_top_macros.svh"

  logic [2:0]  phase_q, phase_d;
  logic [7:0]  opcode_q, opcode_d;
  logic [7:0]  modrm_q, modrm_d;
  logic [15:0] disp_q, disp_d;
  logic [15:0] imm_q, imm_d;
  logic [2:0]  expect_q, expect_d;

  op_kind_e    kind;
  logic        mrm;
  logic [2:0]  dstart;
  logic [2:0]  dend;
  logic [2:0]  phase_nx;
  logic [2:0]  len;
  logic [2:0]  slot;
  logic        sel_hi;
  logic [15:0] disp_ext;
  logic [15:0] imm_ext;

  // Next state of the holds and completion
  always_comb begin
    phase_d  = phase_q;
    opcode_d = opcode_q;
    modrm_d  = modrm_q;
    disp_d   = disp_q;
    imm_d    = imm_q;
    expect_d = expect_q;
    done_o   = 1'b0;
    len      = 3'd0;
    kind     = (phase_q == 3'd0) ? classify(byte_i) : classify(opcode_q);
    mrm      = has_modrm(kind);
    dstart   = mrm ? 3'd2 : 3'd1;
    dend     = dstart + (mrm ? {1'b0, disp_count(modrm_q)} : 3'd0);
    phase_nx = phase_q + 3'd1;
    slot     = 3'd0;
    sel_hi   = 1'b0;
    if (take_i) begin
      if (phase_q == 3'd0) begin
        opcode_d = byte_i;
        modrm_d  = 8'h00;
        disp_d   = 16'h0000;
        imm_d    = 16'h0000;
        if (kind == KIND_UNKNOWN) begin
          done_o   = 1'b1;
          len      = 3'd1;
          expect_d = 3'd0;
        end else begin
          phase_d  = 3'd1;
          expect_d = mrm ? 3'd2 : 3'd1 + {1'b0, imm_count(kind, byte_i)};
        end
      end else begin
        if (mrm && (phase_q == 3'd1)) begin
          modrm_d  = byte_i;
          expect_d = 3'd2 + {1'b0, disp_count(byte_i)} + {1'b0, imm_count(kind, opcode_q)};
        end else if (phase_q < dend) begin
          slot   = phase_q - dstart;
          sel_hi = slot[0];
          disp_d = disp_q | (sel_hi ? {byte_i, 8'h00} : {8'h00, byte_i});
        end else begin
          slot   = phase_q - dend;
          sel_hi = slot[0];
          imm_d  = imm_q | (sel_hi ? {byte_i, 8'h00} : {8'h00, byte_i});
        end
        if (phase_nx >= expect_d) begin
          done_o   = 1'b1;
          len      = expect_d;
          phase_d  = 3'd0;
          expect_d = 3'd0;
        end else begin
          phase_d = phase_nx;
        end
      end
    end
  end

  // Field assembly from the updated holds
  always_comb begin
    res_o = '0;
    disp_ext = disp_d;
    imm_ext  = imm_d;
    res_o.op_kind      = kind;
    res_o.instr_length = len;
    if (kind != KIND_UNKNOWN) begin
      res_o.wide_bit     = wide_of(kind, opcode_d);
      res_o.sign_ext_bit = (kind == KIND_IMM_GRP) ? opcode_d[1] : 1'b0;
      res_o.dir_bit      = ((kind == KIND_MOV_RM) || (kind == KIND_ADD_RM)) ? opcode_d[1] : 1'b0;
      if (mrm) begin
        res_o.mode_field = modrm_d[7:6];
        res_o.reg_num    = modrm_d[5:3];
        res_o.rm_field   = modrm_d[2:0];
        if ((disp_count(modrm_d) == 2'd1) && disp_d[7]) disp_ext = {8'hFF, disp_d[7:0]};
      end else if (kind == KIND_MOV_IMM) begin
        res_o.reg_num = opcode_d[2:0];
      end
      if (res_o.sign_ext_bit && imm_d[7]) imm_ext = {8'hFF, imm_d[7:0]};
      res_o.displacement = disp_ext;
      res_o.immediate    = imm_ext;
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= 3'd0;
      opcode_q <= 8'h00;
      modrm_q  <= 8'h00;
      disp_q   <= 16'h0000;
      imm_q    <= 16'h0000;
      expect_q <= 3'd0;
    end else begin
      phase_q  <= phase_d;
      opcode_q <= opcode_d;
      modrm_q  <= modrm_d;
      disp_q   <= disp_d;
      imm_q    <= imm_d;
      expect_q <= expect_d;
    end
  end

  `X86PD_ASSERT(a_idle_no_len, (phase_q == 3'd0) == (expect_q == 3'd0), "phase/length mismatch")
  `X86PD_ASSERT_IMP(a_phase_below_len, phase_q != 3'd0, phase_q < expect_q, "phase past length")
  `X86PD_ASSERT_IMP(a_one_byte_unknown, done_o && (phase_q == 3'd0),
                    res_o.op_kind == KIND_UNKNOWN, "known opcode finished on first byte")
  `X86PD_ASSERT_IMP(a_len_matches, done_o && (phase_q != 3'd0),
                    res_o.instr_length == phase_q + 3'd1, "length differs from bytes taken")

endmodule

>>> rtl/core/x86pd_outreg.sv
// Result register that drives the output channel and holds a result
// until its transfer. Uses x86pd_pkg and x86pd_res_if.
module x86pd_outreg
  import x86pd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  result_t     res_i,
  output logic        free_o,
  x86pd_res_if.source result_o
);

  logic    valid_q, valid_d;
  result_t res_q;

  // Room for a new result when empty or the held one transfers now
  assign free_o = !valid_q || result_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (load_i)               valid_d = 1'b1;
    else if (result_o.ready)  valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else         valid_q <= valid_d;
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    if (load_i) res_q <= res_i;
  end

  assign result_o.valid        = valid_q;
  assign result_o.op_kind      = res_q.op_kind;
  assign result_o.dir_bit      = res_q.dir_bit;
  assign result_o.wide_bit     = res_q.wide_bit;
  assign result_o.sign_ext_bit = res_q.sign_ext_bit;
  assign result_o.mode_field   = res_q.mode_field;
  assign result_o.reg_num      = res_q.reg_num;
  assign result_o.rm_field     = res_q.rm_field;
  assign result_o.displacement = res_q.displacement;
  assign result_o.immediate    = res_q.immediate;
  assign result_o.instr_length = res_q.instr_length;

endmodule
